// ===== rtl/core/gwcd_pkg.sv =====
// gwcd_pkg: constants and small lookup functions for the GPS week to civil date block.
// Shared by gps_week_to_civil_date, gwcd_cal and gwcd_tod. No dependencies.
package gwcd_pkg;

	// Reciprocal scalings for constant division, estimate is low by at most one
	localparam logic [20:0] MS_TO_S_RECIP = 21'd1073741; // 2^30 / 1000
	localparam int          MS_TO_S_SHIFT = 30;
	localparam logic [9:0]  MS_PER_S      = 10'd1000;

	localparam logic [7:0]  S_TO_DAY_RECIP = 8'd194;      // 2^24 / 86400
	localparam int          S_TO_DAY_SHIFT = 24;
	localparam logic [16:0] SEC_PER_DAY    = 17'd86400;

	localparam logic [5:0]  S_TO_HOUR_RECIP = 6'd36;      // 2^17 / 3600
	localparam int          S_TO_HOUR_SHIFT = 17;
	localparam logic [11:0] SEC_PER_HOUR    = 12'd3600;

	localparam logic [6:0]  S_TO_MIN_RECIP = 7'd68;       // 2^12 / 60
	localparam int          S_TO_MIN_SHIFT = 12;
	localparam logic [5:0]  SEC_PER_MIN    = 6'd60;

	localparam logic [16:0] MJD_GPS_EPOCH  = 17'd44244;
	localparam logic [16:0] MJD_MAR_1_2100 = 17'd88128;
	localparam logic [21:0] B_OFFSET       = 22'd2401538;  // JD offset plus day shift
	localparam logic [25:0] X_OFFSET       = 26'd48028318; // 20*B_OFFSET - 2442

	localparam logic [13:0] C_RECIP = 14'd9186;            // 2^26 / 7305
	localparam int          C_SHIFT = 26;
	localparam logic [12:0] C_DIV   = 13'd7305;
	localparam logic [10:0] D_MUL   = 11'd1461;
	localparam logic [12:0] YEAR_BASE = 13'd4715;

	// smallest b-d that reaches month index k: ceil(k * 30.6001)
	localparam logic [15:1][8:0] E_THRESH = {
		9'd460, 9'd429, 9'd398, 9'd368, 9'd337, 9'd307, 9'd276, 9'd245,
		9'd215, 9'd184, 9'd154, 9'd123, 9'd92, 9'd62, 9'd31};

	// floor(e * 30.6001)
	localparam logic [15:0][8:0] F_OF_E = {
		9'd459, 9'd428, 9'd397, 9'd367, 9'd336, 9'd306, 9'd275, 9'd244,
		9'd214, 9'd183, 9'd153, 9'd122, 9'd91, 9'd61, 9'd30, 9'd0};

	localparam logic [3:0] E_WRAP = 4'd14;

	function automatic logic [3:0] e_of_bd(input logic [8:0] bd);
		logic [3:0] n;
		n = '0;
		for (int k = 1; k <= 15; k++) begin
			if (bd >= E_THRESH[k]) n = n + 4'd1;
		end
		return n;
	endfunction

endpackage

// ===== rtl/core/gwcd_tod.sv =====
// gwcd_tod: seconds of day to hour, minute, second in six register stages (_s5.._s10).
// Depends on gwcd_pkg for the reciprocal constants.
module gwcd_tod import gwcd_pkg::*; (
	input  logic        clk,
	input  logic [16:0] sod,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	logic [16:0] sod_s5;
	logic [4:0]  hest_s5;
	logic [4:0]  hour_s6, hour_s7, hour_s8, hour_s9, hour_s10;
	logic [11:0] rem_s6, rem_s7;
	logic [5:0]  mest_s7;
	logic [5:0]  minute_s8, minute_s9, minute_s10;
	logic [5:0]  second_s8, second_s9, second_s10;

	logic [22:0] hprod;
	logic [16:0] hrem;
	logic [18:0] mprod;
	logic [11:0] mrem;

	always_comb begin
		hprod = 23'(sod) * 23'(S_TO_HOUR_RECIP);
		hrem  = sod_s5 - 17'(hest_s5) * 17'(SEC_PER_HOUR);
		mprod = 19'(rem_s6) * 19'(S_TO_MIN_RECIP);
		mrem  = rem_s7 - 12'(mest_s7) * 12'(SEC_PER_MIN);
	end

	always_ff @(posedge clk) begin
		sod_s5  <= sod;
		hest_s5 <= 5'(hprod >> S_TO_HOUR_SHIFT);

		// estimate may be one short
		if (hrem >= 17'(SEC_PER_HOUR)) begin
			hour_s6 <= hest_s5 + 5'd1;
			rem_s6  <= 12'(hrem - 17'(SEC_PER_HOUR));
		end else begin
			hour_s6 <= hest_s5;
			rem_s6  <= 12'(hrem);
		end

		hour_s7 <= hour_s6;
		rem_s7  <= rem_s6;
		mest_s7 <= 6'(mprod >> S_TO_MIN_SHIFT);

		hour_s8 <= hour_s7;
		if (mrem >= 12'(SEC_PER_MIN)) begin
			minute_s8 <= mest_s7 + 6'd1;
			second_s8 <= 6'(mrem - 12'(SEC_PER_MIN));
		end else begin
			minute_s8 <= mest_s7;
			second_s8 <= 6'(mrem);
		end

		hour_s9    <= hour_s8;
		minute_s9  <= minute_s8;
		second_s9  <= second_s8;
		hour_s10   <= hour_s9;
		minute_s10 <= minute_s9;
		second_s10 <= second_s9;
	end

	assign hour   = hour_s10;
	assign minute = minute_s10;
	assign second = second_s10;

endmodule

// ===== rtl/core/gwcd_cal.sv =====
// gwcd_cal: modified Julian day to Gregorian year, month, day in six stages (_s5.._s10).
// Depends on gwcd_pkg for offsets, reciprocals and the month tables.
module gwcd_cal import gwcd_pkg::*; (
	input  logic        clk,
	input  logic [16:0] mjd,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic        beyond_valid
);

	logic [25:0] x_s5, x_s6;
	logic [21:0] b_s5, b_s6, b_s7;
	logic        bey_s5, bey_s6, bey_s7, bey_s8, bey_s9, bey_s10;
	logic [12:0] cest_s6;
	logic [12:0] c_s7, c_s8, c_s9;
	logic [8:0]  bd_s8, bd_s9;
	logic [3:0]  e_s9;
	logic [11:0] year_s10;
	logic [3:0]  month_s10;
	logic [4:0]  day_s10;

	logic [39:0] cprod;
	logic [25:0] crem;
	logic [23:0] dprod;
	logic [21:0] d;
	logic [3:0]  mo;

	always_comb begin
		cprod = 40'(x_s5) * 40'(C_RECIP);
		crem  = x_s6 - 26'(cest_s6) * 26'(C_DIV);
		dprod = 24'(c_s7) * 24'(D_MUL);
		d     = dprod[23:2];
		// months run March..February, e of 14 and 15 wrap to January, February
		mo    = (e_s9 >= E_WRAP) ? e_s9 - 4'd13 : e_s9 - 4'd1;
	end

	always_ff @(posedge clk) begin
		x_s5   <= 26'(mjd) * 26'd20 + X_OFFSET;
		b_s5   <= 22'(mjd) + B_OFFSET;
		bey_s5 <= mjd >= MJD_MAR_1_2100;

		x_s6    <= x_s5;
		b_s6    <= b_s5;
		bey_s6  <= bey_s5;
		cest_s6 <= 13'(cprod >> C_SHIFT);

		b_s7   <= b_s6;
		bey_s7 <= bey_s6;
		c_s7   <= (crem >= 26'(C_DIV)) ? cest_s6 + 13'd1 : cest_s6;

		c_s8   <= c_s7;
		bey_s8 <= bey_s7;
		bd_s8  <= 9'(b_s7 - d);

		c_s9   <= c_s8;
		bd_s9  <= bd_s8;
		bey_s9 <= bey_s8;
		e_s9   <= e_of_bd(bd_s8);

		bey_s10   <= bey_s9;
		day_s10   <= 5'(bd_s9 - F_OF_E[e_s9]);
		month_s10 <= mo;
		year_s10  <= 12'(c_s9 - YEAR_BASE - ((mo >= 4'd3) ? 13'd1 : 13'd0));
	end

	assign year         = year_s10;
	assign month        = month_s10;
	assign day          = day_s10;
	assign beyond_valid = bey_s10;

endmodule

// ===== rtl/core/gps_week_to_civil_date.sv =====
// gps_week_to_civil_date: GPS week and millisecond of week to civil date and time.
// Depends on gwcd_pkg, gwcd_cal (date stages) and gwcd_tod (time of day stages).
//
// Usage:
//   Raise start with week_num and ms_of_week; the beat is taken on any edge where
//   start is high and busy is low. busy is always low: the pipeline takes a new
//   beat every cycle.
//   Once an accepted beat has passed all stages, done is high for exactly one
//   cycle with year, month, day, hour, minute, second and beyond_valid on the
//   result ports. Throughput is one beat per cycle; results leave in the order
//   taken.
//   Stages 1-4 split milliseconds into day count and seconds of day and form the
//   MJD; stages 5-10 run the calendar steps and the time of day split in parallel.
//   Milliseconds are truncated. beyond_valid flags dates from 1 March 2100 on.
//   The receiver cannot stall: whatever is on the ports while done is high is
//   the result and must be taken then.
//   Reset (arst_n low) clears all valid bits; beats in flight are dropped and no
//   done is given until new beats arrive.
module gps_week_to_civil_date import gwcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [12:0] week_num,
	input  logic [29:0] ms_of_week,
	output logic        done,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic        beyond_valid
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	logic [29:0] ms_s1;
	logic [12:0] week_s1;
	logic [20:0] sest_s1;
	logic [20:0] sec_s2, sec_s3;
	logic [15:0] wk7_s2, wk7_s3;
	logic [3:0]  dest_s3;
	logic [16:0] sod_s4;
	logic [16:0] mjd_s4;

	logic [50:0] sprod;
	logic [30:0] srem;
	logic [28:0] dprod;
	logic [20:0] drem;
	logic [3:0]  days;
	logic [16:0] sod;

	assign busy = 1'b0;

	always_comb begin
		sprod = 51'(ms_of_week) * 51'(MS_TO_S_RECIP);
		srem  = 31'(ms_s1) - 31'(sest_s1) * 31'(MS_PER_S);
		dprod = 29'(sec_s2) * 29'(S_TO_DAY_RECIP);
		drem  = sec_s3 - 21'(dest_s3) * 21'(SEC_PER_DAY);
		// reciprocal estimate may be one short
		if (drem >= 21'(SEC_PER_DAY)) begin
			days = dest_s3 + 4'd1;
			sod  = 17'(drem - 21'(SEC_PER_DAY));
		end else begin
			days = dest_s3;
			sod  = 17'(drem);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s1  <= start & ~busy;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		ms_s1   <= ms_of_week;
		week_s1 <= week_num;
		sest_s1 <= 21'(sprod >> MS_TO_S_SHIFT);

		sec_s2 <= (srem >= 31'(MS_PER_S)) ? sest_s1 + 21'd1 : sest_s1;
		wk7_s2 <= 16'(week_s1) * 16'd7;

		sec_s3  <= sec_s2;
		wk7_s3  <= wk7_s2;
		dest_s3 <= 4'(dprod >> S_TO_DAY_SHIFT);

		sod_s4 <= sod;
		mjd_s4 <= 17'(wk7_s3) + 17'(days) + MJD_GPS_EPOCH;
	end

	gwcd_cal u_cal (
		.clk          (clk),
		.mjd          (mjd_s4),
		.year         (year),
		.month        (month),
		.day          (day),
		.beyond_valid (beyond_valid)
	);

	gwcd_tod u_tod (
		.clk    (clk),
		.sod    (sod_s4),
		.hour   (hour),
		.minute (minute),
		.second (second)
	);

	assign done = v_s10;

endmodule
